>>> sv/rpt_pkg.sv
// Shared types and constants of the retransmit pending table.
package rpt_pkg;

  typedef enum logic [1:0] {
    REQ_PUBLISH = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    EV_ACCEPT = 2'd0,
    EV_REJECT = 2'd1,
    EV_RESEND = 2'd2,
    EV_DROP   = 2'd3
  } event_e;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned SlotOutW   = 4;

  // Input word.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] ack_seq;
    logic [15:0] ack_sender;
    logic [15:0] retry_ticks;
    logic [7:0]  retry_limit;
    logic [15:0] buffer_handle;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] seq_out;
    logic [15:0] handle_out;
    logic [3:0]  slot_out;
    logic        last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input word
    logic ack_step; // apply the ack to the scan slot
    logic tick_inc; // advance time
    logic scan_rst; // restart scan index
    logic scan_chk; // examine the scan slot
    logic emit_pub; // present the publish result
  } rpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       scan_end;  // scan index at last slot
  } rpt_sts_t;

endpackage

>>> sv/rpt_if.sv
// Valid/ready channel interface.
interface rpt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/rpt_cfg_if.sv
// Configuration write channel interface.
interface rpt_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/retransmit_pending_table.sv
// Retransmit pending table: top level.
// The block keeps up to TABLE_DEPTH unacknowledged messages. Words arrive on
// req_if (valid/ready); results leave on res_if; own_id is written on cfg_if.
// A publish is decoded in the cycle after accept: its single result (accepted
// or rejected, table full) is loaded into the output register from decode.
// An ack walks the table one slot per cycle and gives no result. A tick
// advances time and walks the table one slot per cycle, loading each resend
// or drop into the output register. An ack or tick holds the block until its
// walk over the table ends. One word is worked on at a time. When the
// receiver stalls, a tick walk halts on the next slot and a publish waits in
// decode until the waiting result is taken. Reset empties the table, clears
// time, the sequence counter and own_id; no clearing pass is needed since
// the scan reads only valid slots and an ack on a free slot only clears it.
// The last field marks the final result of each word that gives results.
module retransmit_pending_table import rpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rpt_if.sink   req_if,
  rpt_if.source res_if,
  rpt_cfg_if.sink cfg_if
);
  rpt_cmd_t cmd;
  rpt_sts_t sts;
  logic     in_ready, in_fire, res_valid, res_take;
  res_t     res;

  assign req_if.ready = in_ready;
  assign in_fire      = req_if.valid && in_ready;
  assign cfg_if.ready = 1'b1;
  assign res_take     = res_valid && res_if.ready;
  assign res_if.valid = res_valid;
  assign res_if.data  = res;

  rpt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i   (in_fire),
    .res_valid_i (res_valid),
    .res_take_i  (res_take),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  rpt_datapath #(.Depth(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .req_i       (req_if.data),
    .cfg_we_i    (cfg_if.valid),
    .cfg_data_i  (cfg_if.data),
    .cmd_i       (cmd),
    .res_take_i  (res_take),
    .sts_o       (sts),
    .res_valid_o (res_valid),
    .res_o       (res)
  );
endmodule

>>> sv/rpt_datapath.sv
// Entry table, counters and result register of the retransmit pending table.
module rpt_datapath import rpt_pkg::*; #(
  parameter int unsigned Depth = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  logic     cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  rpt_cmd_t cmd_i,
  input  logic     res_take_i,
  output rpt_sts_t sts_o,
  output logic     res_valid_o,
  output res_t     res_o
);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  req_t              req_q;
  logic [15:0]       own_id_q;
  logic [Depth-1:0]  valid_q;
  logic [31:0]       seq_q [Depth];
  logic [15:0]       handle_q [Depth];
  logic [31:0]       sent_q [Depth];
  logic [15:0]       intv_q [Depth];
  logic [7:0]        limit_q [Depth];
  logic [7:0]        att_q [Depth];
  logic [31:0]       next_seq_q, time_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   cnt_q;
  logic              res_valid_q;
  res_t              res_q;

  // Lowest free slot.
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // Expiry test of the scanned slot.
  logic [31:0] elapsed;
  logic        expired, capped;
  assign elapsed = time_q - sent_q[idx_q];
  assign expired = valid_q[idx_q] && (elapsed >= {16'd0, intv_q[idx_q]});
  assign capped  = (cnt_q == CntW'(MaxResults));

  // Whether any later slot can still produce a result decides the last flag.
  logic more;
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      if (IdxW'(i) > idx_q && valid_q[i] &&
          ((time_q - sent_q[i]) >= {16'd0, intv_q[i]})) begin
        more = 1'b1;
      end
    end
  end

  // A new result is loaded by a publish or by a scan hit.
  logic res_load;
  assign res_load = cmd_i.emit_pub || (cmd_i.scan_chk && expired && !capped);

  assign sts_o.req_type = req_q.req_type;
  assign sts_o.scan_end = (idx_q == IdxW'(Depth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      valid_q     <= '0;
      next_seq_q  <= '0;
      time_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_id_q <= cfg_data_i;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        req_q <= req_i;
      end
      if (cmd_i.tick_inc) begin
        time_q <= time_q + 32'd1;
      end
      if (cmd_i.scan_rst) begin
        idx_q <= '0;
        cnt_q <= '0;
      end
      // Publish: store in the lowest free slot or reject.
      if (cmd_i.emit_pub) begin
        res_q.seq_out    <= next_seq_q;
        res_q.handle_out <= req_q.buffer_handle;
        res_q.last       <= 1'b1;
        if (free_found) begin
          valid_q[free_idx]  <= 1'b1;
          seq_q[free_idx]    <= next_seq_q;
          handle_q[free_idx] <= req_q.buffer_handle;
          sent_q[free_idx]   <= time_q;
          intv_q[free_idx]   <= req_q.retry_ticks;
          limit_q[free_idx]  <= req_q.retry_limit;
          att_q[free_idx]    <= 8'd1;
          next_seq_q         <= next_seq_q + 32'd1;
          res_q.event_res    <= EV_ACCEPT;
          res_q.slot_out     <= SlotOutW'(free_idx);
        end else begin
          res_q.event_res <= EV_REJECT;
          res_q.slot_out  <= '0;
        end
      end
      // Ack: one slot per cycle.
      if (cmd_i.ack_step) begin
        if (req_q.ack_sender == own_id_q && seq_q[idx_q] == req_q.ack_seq) begin
          valid_q[idx_q] <= 1'b0;
        end
        idx_q <= idx_q + IdxW'(1);
      end
      // Tick scan: one slot per cycle while no waiting result blocks it; a hit below the cap loads the result register.
      if (cmd_i.scan_chk) begin
        if (expired && !capped) begin
          res_q.seq_out    <= seq_q[idx_q];
          res_q.handle_out <= handle_q[idx_q];
          res_q.slot_out   <= SlotOutW'(idx_q);
          res_q.last       <= !more || (cnt_q == CntW'(MaxResults - 1));
          cnt_q            <= cnt_q + CntW'(1);
          if (att_q[idx_q] >= limit_q[idx_q]) begin
            valid_q[idx_q]  <= 1'b0;
            res_q.event_res <= EV_DROP;
          end else begin
            sent_q[idx_q]   <= time_q;
            att_q[idx_q]    <= att_q[idx_q] + 8'd1;
            res_q.event_res <= EV_RESEND;
          end
        end
        if (idx_q != IdxW'(Depth - 1)) begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // For a table of up to 16 slots, a result never claims a slot beyond the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ({28'd0, res_q.slot_out} < 32'(Depth) || Depth > 16))
    else $error("result slot out of range");
  // An accepted publish bumps the sequence counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_pub && free_found) |=> next_seq_q == $past(next_seq_q) + 32'd1)
    else $error("sequence not advanced");
  // The per-tick result count never exceeds the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxResults))
    else $error("result cap exceeded");
endmodule

>>> sv/rpt_ctrl.sv
// Sequencer of the retransmit pending table.
module rpt_ctrl import rpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     res_valid_i,
  input  logic     res_take_i,
  input  rpt_sts_t sts_i,
  output logic     in_ready_o,
  output rpt_cmd_t cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_ACK, S_SCAN, S_WAIT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Commands are decoded from the state and the datapath status.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_fire_i;
    case (state_q)
      S_DECODE: begin
        cmd_o.scan_rst = 1'b1;
        cmd_o.emit_pub = (sts_i.req_type == REQ_PUBLISH) && !res_valid_i;
        cmd_o.tick_inc = (sts_i.req_type == REQ_TICK);
      end
      S_ACK:  cmd_o.ack_step = 1'b1;
      S_SCAN: cmd_o.scan_chk = !res_valid_i || res_take_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (in_fire_i) state_q <= S_DECODE;
        S_DECODE: begin
          case (sts_i.req_type)
            REQ_PUBLISH: if (!res_valid_i) state_q <= S_IDLE;
            REQ_ACK:     state_q <= S_ACK;
            REQ_TICK:    state_q <= S_SCAN;
            default:     state_q <= S_IDLE;
          endcase
        end
        S_ACK: if (sts_i.scan_end) state_q <= S_IDLE;
        S_SCAN: begin
          if (cmd_o.scan_chk && sts_i.scan_end) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A new word is never taken while an earlier one is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> state_q == S_DECODE)
    else $error("accept outside idle");
  // Neither the scan nor a publish overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_chk || cmd_o.emit_pub) |-> (!res_valid_i || res_take_i))
    else $error("result overwritten");
  // Publish and tick commands are exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_pub && cmd_o.tick_inc))
    else $error("conflicting commands");
endmodule
